FILE: hdl/rrws_pkg.sv
package rrws_pkg;

   localparam int MAX_ENTRIES_DEFAULT = 64;
   localparam int COUNT_BITS_DEFAULT  = 8;

   localparam int FIELD_W  = 8;
   localparam int FRAC_W   = 16;
   localparam int SEL_W    = 6;
   localparam int STATUS_W = 3;
   localparam int CSR_W    = 2;

   typedef logic [SEL_W-1:0] sel_index_type;
   typedef logic [CSR_W-1:0] csr_index_type;

   localparam csr_index_type REG_ENABLE = 2'd0;
   localparam csr_index_type REG_RANDOM = 2'd1;
   localparam csr_index_type REG_ONCE   = 2'd2;

   localparam logic CMD_APPEND = 1'b0;
   localparam logic CMD_SELECT = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      ST_SELECTED = 3'd0,
      ST_IDLE     = 3'd1,
      ST_NONE     = 3'd2,
      ST_APPENDED = 3'd3,
      ST_FULL     = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_BEGIN,
      S_START,
      S_READ,
      S_CHECK,
      S_EMIT
   } ctrl_state_type;

   typedef struct packed {
      logic load;
      logic append;
      logic sel_idle;
      logic sel_begin;
      logic set_start;
      logic advance;
      logic hit;
      logic miss;
      logic emit;
   } dp_cmd_type;

   typedef struct packed {
      logic is_select;
      logic enabled;
      logic empty;
      logic eligible;
      logic last;
      logic out_free;
   } dp_status_type;

endpackage

FILE: hdl/rrws_ctrl.sv
module rrws_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  rrws_pkg::dp_status_type stat,
   output rrws_pkg::dp_cmd_type    cmd
);

   rrws_pkg::ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rrws_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         rrws_pkg::S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = rrws_pkg::S_DECODE;
            end
         end
         rrws_pkg::S_DECODE: begin
            if (!stat.is_select) begin
               cmd.append = 1'b1;
               state_in   = rrws_pkg::S_EMIT;
            end else if (!stat.enabled || stat.empty) begin
               cmd.sel_idle = 1'b1;
               state_in     = rrws_pkg::S_EMIT;
            end else begin
               cmd.sel_begin = 1'b1;
               state_in      = rrws_pkg::S_START;
            end
         end
         rrws_pkg::S_BEGIN: begin
            state_in = rrws_pkg::S_START;
         end
         rrws_pkg::S_START: begin
            cmd.set_start = 1'b1;
            state_in      = rrws_pkg::S_READ;
         end
         rrws_pkg::S_READ: begin
            state_in = rrws_pkg::S_CHECK;
         end
         rrws_pkg::S_CHECK: begin
            if (stat.eligible) begin
               cmd.hit  = 1'b1;
               state_in = rrws_pkg::S_EMIT;
            end else if (stat.last) begin
               cmd.miss = 1'b1;
               state_in = rrws_pkg::S_EMIT;
            end else begin
               cmd.advance = 1'b1;
               state_in    = rrws_pkg::S_READ;
            end
         end
         rrws_pkg::S_EMIT: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = rrws_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = rrws_pkg::S_IDLE;
         end
      endcase
   end

endmodule

FILE: hdl/rrws_dp.sv
module rrws_dp #(
   parameter int MAX_ENTRIES = rrws_pkg::MAX_ENTRIES_DEFAULT,
   parameter int COUNT_BITS  = rrws_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_command,
   input  logic [rrws_pkg::FIELD_W-1:0]  req_entry_low,
   input  logic [rrws_pkg::FIELD_W-1:0]  req_entry_high,
   input  logic [rrws_pkg::FIELD_W-1:0]  req_player_count,
   input  logic [rrws_pkg::FRAC_W-1:0]   req_random_fraction,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [rrws_pkg::STATUS_W-1:0] rsp_status,
   output logic [rrws_pkg::SEL_W-1:0]    rsp_selected_index,
   input  logic                          csr_write_enable,
   input  rrws_pkg::csr_index_type       csr_index,
   input  logic                          csr_write_data,
   input  rrws_pkg::dp_cmd_type          cmd,
   output rrws_pkg::dp_status_type       stat
);

   localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
   localparam int PROD_W = rrws_pkg::FRAC_W + CNT_W;

   logic                        enable_ff, random_ff, once_ff;
   logic                        command_ff;
   logic [COUNT_BITS-1:0]       low_item_ff, high_item_ff, cnt_item_ff;
   logic [rrws_pkg::FRAC_W-1:0] frac_ff;

   logic [COUNT_BITS-1:0]  low_mem [MAX_ENTRIES];
   logic [COUNT_BITS-1:0]  high_mem [MAX_ENTRIES];
   logic [COUNT_BITS-1:0]  low_rd_ff, high_rd_ff;

   logic [MAX_ENTRIES-1:0] visited_ff;
   logic [CNT_W-1:0]       visit_count_ff;
   logic [CNT_W-1:0]       count_ff;
   logic [CNT_W-1:0]       scan_ptr_ff;
   logic [IDX_W-1:0]       pt_ff, base_ff, k_ff;
   logic [PROD_W-1:0]      product_ff;

   rrws_pkg::status_type    res_status_ff;
   rrws_pkg::sel_index_type res_index_ff;
   logic                    rsp_valid_ff;
   rrws_pkg::status_type    rsp_status_ff;
   rrws_pkg::sel_index_type rsp_index_ff;

   logic             full, all_visited, write_entry;
   logic [IDX_W-1:0] scan_mod, start_idx, pt_next, base_b, base_c;
   logic [CNT_W-1:0] pt_inc, base_inc, b_inc;

   assign full        = (count_ff == CNT_W'(MAX_ENTRIES));
   assign all_visited = (visit_count_ff == count_ff);
   assign write_entry = cmd.append && !full;

   assign scan_mod  = (scan_ptr_ff == count_ff) ? '0 : scan_ptr_ff[IDX_W-1:0];
   assign start_idx = random_ff ? product_ff[rrws_pkg::FRAC_W +: IDX_W] : scan_mod;

   assign pt_inc   = CNT_W'(pt_ff) + 1'b1;
   assign pt_next  = (pt_inc == count_ff) ? '0 : pt_inc[IDX_W-1:0];
   assign base_inc = CNT_W'(base_ff) + 1'b1;
   assign base_b   = (base_inc == count_ff) ? '0 : base_inc[IDX_W-1:0];
   assign b_inc    = CNT_W'(base_b) + 1'b1;
   assign base_c   = (b_inc == count_ff) ? '0 : b_inc[IDX_W-1:0];

   assign stat.is_select = (command_ff == rrws_pkg::CMD_SELECT);
   assign stat.enabled   = enable_ff;
   assign stat.empty     = (count_ff == '0);
   assign stat.eligible  = (high_rd_ff != '0) && !visited_ff[pt_ff] &&
                           (low_rd_ff <= cnt_item_ff) && (high_rd_ff >= cnt_item_ff);
   assign stat.last      = (CNT_W'(k_ff) == count_ff - 1'b1);
   assign stat.out_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_selected_index = rsp_index_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b1;
         random_ff <= 1'b0;
         once_ff   <= 1'b0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            rrws_pkg::REG_ENABLE: enable_ff <= csr_write_data;
            rrws_pkg::REG_RANDOM: random_ff <= csr_write_data;
            rrws_pkg::REG_ONCE:   once_ff   <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (write_entry) begin
         low_mem[count_ff[IDX_W-1:0]]  <= low_item_ff;
         high_mem[count_ff[IDX_W-1:0]] <= high_item_ff;
      end
      low_rd_ff  <= low_mem[pt_ff];
      high_rd_ff <= high_mem[pt_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         command_ff   <= req_command;
         low_item_ff  <= COUNT_BITS'(req_entry_low);
         high_item_ff <= COUNT_BITS'(req_entry_high);
         cnt_item_ff  <= COUNT_BITS'(req_player_count);
         frac_ff      <= req_random_fraction;
      end
      if (cmd.sel_begin) begin
         product_ff <= PROD_W'(frac_ff) * PROD_W'(count_ff - 1'b1);
         k_ff       <= '0;
      end
      if (cmd.set_start) begin
         pt_ff   <= start_idx;
         base_ff <= start_idx;
      end
      if (cmd.advance) begin
         pt_ff <= pt_next;
         k_ff  <= k_ff + 1'b1;
      end
      if (cmd.append) begin
         res_status_ff <= full ? rrws_pkg::ST_FULL : rrws_pkg::ST_APPENDED;
         res_index_ff  <= '0;
      end
      if (cmd.sel_idle) begin
         res_status_ff <= rrws_pkg::ST_IDLE;
         res_index_ff  <= '0;
      end
      if (cmd.hit) begin
         res_status_ff <= rrws_pkg::ST_SELECTED;
         res_index_ff  <= rrws_pkg::sel_index_type'(pt_ff);
      end
      if (cmd.miss) begin
         res_status_ff <= rrws_pkg::ST_NONE;
         res_index_ff  <= '0;
      end
      if (cmd.emit) begin
         rsp_status_ff <= res_status_ff;
         rsp_index_ff  <= res_index_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff       <= '0;
         scan_ptr_ff    <= '0;
         visited_ff     <= '0;
         visit_count_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (write_entry) begin
            count_ff <= count_ff + 1'b1;
         end
         if (cmd.sel_idle && enable_ff) begin
            scan_ptr_ff <= '0;
         end
         if (cmd.sel_begin && once_ff && all_visited) begin
            visited_ff     <= '0;
            visit_count_ff <= '0;
         end
         if (cmd.hit) begin
            scan_ptr_ff <= CNT_W'(pt_ff) + 1'b1;
            if (once_ff) begin
               visited_ff[pt_ff] <= 1'b1;
               visit_count_ff    <= visit_count_ff + 1'b1;
            end
         end
         if (cmd.miss) begin
            // A random start is drawn again for the second pass, so it steps only once.
            scan_ptr_ff <= CNT_W'(random_ff ? base_b : base_c) + 1'b1;
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   a_visit_count_bound: assert property (@(posedge clock) disable iff (reset)
      visit_count_ff <= count_ff)
      else $error("visited count exceeds entry count");

   a_scan_ptr_bound: assert property (@(posedge clock) disable iff (reset)
      scan_ptr_ff <= count_ff)
      else $error("scan pointer beyond entry count");

   a_index_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff != rrws_pkg::ST_SELECTED) |-> rsp_index_ff == '0)
      else $error("nonzero index on a result without selection");

   a_hit_in_table: assert property (@(posedge clock) disable iff (reset)
      cmd.hit |-> CNT_W'(pt_ff) < count_ff)
      else $error("selected entry outside the table");

endmodule

FILE: hdl/round_robin_window_selector_top.sv
// Append and disabled or empty selects: a word is registered on acceptance, its result is
// set in the decode state and registered at the output from the emit state once it is free.
// Select: after decode and a start state, each entry examined (one up to the entry count)
// takes a table read state and a compare state before the result goes to the emit state.
// One word is in work at a time; a new word is taken while the last result waits.
// Synchronous reset empties the table, clears all visited marks and the scan pointer,
// and sets enable to 1 with random and once modes off.
module round_robin_window_selector_top #(
   parameter int MAX_ENTRIES = rrws_pkg::MAX_ENTRIES_DEFAULT,
   parameter int COUNT_BITS  = rrws_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_command,
   input  logic [rrws_pkg::FIELD_W-1:0]  req_entry_low,
   input  logic [rrws_pkg::FIELD_W-1:0]  req_entry_high,
   input  logic [rrws_pkg::FIELD_W-1:0]  req_player_count,
   input  logic [rrws_pkg::FRAC_W-1:0]   req_random_fraction,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [rrws_pkg::STATUS_W-1:0] rsp_status,
   output logic [rrws_pkg::SEL_W-1:0]    rsp_selected_index,
   input  logic                          csr_write_enable,
   input  logic [rrws_pkg::CSR_W-1:0]    csr_index,
   input  logic                          csr_write_data
);

   rrws_pkg::dp_cmd_type    cmd;
   rrws_pkg::dp_status_type stat;

   rrws_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   rrws_dp #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .COUNT_BITS  (COUNT_BITS)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .req_command         (req_command),
      .req_entry_low       (req_entry_low),
      .req_entry_high      (req_entry_high),
      .req_player_count    (req_player_count),
      .req_random_fraction (req_random_fraction),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_status          (rsp_status),
      .rsp_selected_index  (rsp_selected_index),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data),
      .cmd                 (cmd),
      .stat                (stat)
   );

endmodule

FILE: sim/round_robin_window_selector_top_tb.sv
module round_robin_window_selector_top_tb;

   localparam int TABLE_DEPTH = rrws_pkg::MAX_ENTRIES_DEFAULT;
   localparam int SEGMENTS = 8;
   localparam int SEGMENT_WORDS = 75;
   localparam rrws_pkg::csr_index_type REG_UNUSED = 2'd3;

   typedef enum bit {ROW_WORD, ROW_CSR} row_kind_type;

   typedef struct {
      rrws_pkg::status_type    status;
      rrws_pkg::sel_index_type index;
   } pick_type;

   typedef struct {
      row_kind_type                  kind;
      logic                          command;
      logic [rrws_pkg::FIELD_W-1:0]  low;
      logic [rrws_pkg::FIELD_W-1:0]  high;
      logic [rrws_pkg::FIELD_W-1:0]  count;
      logic [rrws_pkg::FRAC_W-1:0]   fraction;
      rrws_pkg::csr_index_type       reg_index;
      logic                          reg_value;
      bit                            typed;
      rrws_pkg::status_type          status;
   } row_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic                          req_command = rrws_pkg::CMD_APPEND;
   logic [rrws_pkg::FIELD_W-1:0]  req_entry_low = '0;
   logic [rrws_pkg::FIELD_W-1:0]  req_entry_high = '0;
   logic [rrws_pkg::FIELD_W-1:0]  req_player_count = '0;
   logic [rrws_pkg::FRAC_W-1:0]   req_random_fraction = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic [rrws_pkg::STATUS_W-1:0] rsp_status;
   logic [rrws_pkg::SEL_W-1:0]    rsp_selected_index;
   logic                          csr_write_enable = 1'b0;
   rrws_pkg::csr_index_type       csr_index = rrws_pkg::REG_ENABLE;
   logic                          csr_write_data = 1'b0;

   // Predictor state.
   logic [rrws_pkg::FIELD_W-1:0] win_lo [TABLE_DEPTH];
   logic [rrws_pkg::FIELD_W-1:0] win_hi [TABLE_DEPTH];
   bit                           seen [TABLE_DEPTH];
   int                           fill = 0;
   int                           cursor = 0;
   bit                           cfg_enable = 1'b1;
   bit                           cfg_random = 1'b0;
   bit                           cfg_once = 1'b0;

   pick_type expected_picks [$];
   row_type  plan [$];
   int       mismatches = 0;
   int       words_sent = 0;
   int       hits = 0;
   int       misses = 0;
   int       refusals = 0;
   int       gap_pct = 0;
   int       stall_pct = 0;
   int       seg_append_pct;
   int       drain;

   logic [2:0] segment_mode [SEGMENTS] =
      '{3'b001, 3'b011, 3'b101, 3'b111, 3'b110, 3'b101, 3'b111, 3'b001};

   round_robin_window_selector_top u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_command        (req_command),
      .req_entry_low      (req_entry_low),
      .req_entry_high     (req_entry_high),
      .req_player_count   (req_player_count),
      .req_random_fraction(req_random_fraction),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_selected_index (rsp_selected_index),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   always #5 clock = ~clock;

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   function automatic void clear_marks_if_all_seen();
      bit all_seen;
      all_seen = 1'b1;
      for (int i = 0; i < fill; i++) begin
         if (!seen[i]) all_seen = 1'b0;
      end
      if (all_seen) begin
         for (int i = 0; i < fill; i++) seen[i] = 1'b0;
      end
   endfunction

   function automatic pick_type predict_selection(logic cmd,
                                                  logic [rrws_pkg::FIELD_W-1:0] lo,
                                                  logic [rrws_pkg::FIELD_W-1:0] hi,
                                                  logic [rrws_pkg::FIELD_W-1:0] cnt,
                                                  logic [rrws_pkg::FRAC_W-1:0] frac);
      pick_type res;
      int n, pt, hit_at, f;
      bit found;
      res.status = rrws_pkg::ST_NONE;
      res.index = '0;
      found = 1'b0;
      hit_at = 0;
      f = int'(frac);
      if (cmd == rrws_pkg::CMD_APPEND) begin
         if (fill >= TABLE_DEPTH) begin
            res.status = rrws_pkg::ST_FULL;
            refusals++;
         end else begin
            win_lo[fill] = lo;
            win_hi[fill] = hi;
            seen[fill] = 1'b0;
            fill++;
            res.status = rrws_pkg::ST_APPENDED;
         end
      end else if (!cfg_enable) begin
         res.status = rrws_pkg::ST_IDLE;
      end else if (fill == 0) begin
         cursor = 0;
         res.status = rrws_pkg::ST_IDLE;
      end else begin
         n = fill;
         if (cfg_once) clear_marks_if_all_seen();
         for (int pass = 0; pass < 2 && !found; pass++) begin
            if (cfg_random) cursor = (f * (n - 1)) >>> 16;
            pt = cursor % n;
            for (int k = 0; k < n && !found; k++) begin
               if (win_hi[pt] != 0 && !seen[pt] && win_lo[pt] <= cnt && win_hi[pt] >= cnt)
               begin
                  found = 1'b1;
                  hit_at = pt;
               end else begin
                  pt = (pt + 1) % n;
               end
            end
            if (found) begin
               cursor = hit_at;
            end else begin
               if (cfg_once) clear_marks_if_all_seen();
               cursor = (cursor % n + 1) % n;
            end
         end
         if (found && cfg_once) seen[hit_at] = 1'b1;
         cursor = cursor + 1;
         if (found) begin
            res.status = rrws_pkg::ST_SELECTED;
            res.index = rrws_pkg::sel_index_type'(hit_at);
            hits++;
         end else begin
            misses++;
         end
      end
      return res;
   endfunction

   // Drives one word after a random gap and records its expected result on acceptance.
   task automatic send_word(input logic cmd, input logic [rrws_pkg::FIELD_W-1:0] lo,
                            input logic [rrws_pkg::FIELD_W-1:0] hi,
                            input logic [rrws_pkg::FIELD_W-1:0] cnt,
                            input logic [rrws_pkg::FRAC_W-1:0] frac, input bit typed,
                            input rrws_pkg::status_type typed_status);
      pick_type res;
      @(negedge clock);
      while ($urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_entry_low <= lo;
      req_entry_high <= hi;
      req_player_count <= cnt;
      req_random_fraction <= frac;
      do @(posedge clock); while (req_stall);
      res = predict_selection(cmd, lo, hi, cnt, frac);
      if (typed) begin
         res.status = typed_status;
         res.index = '0;
      end
      expected_picks.push_back(res);
      words_sent++;
   endtask

   task automatic write_register(input rrws_pkg::csr_index_type idx, input logic value);
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_picks.size() != 0) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      case (idx)
         rrws_pkg::REG_ENABLE: cfg_enable = value;
         rrws_pkg::REG_RANDOM: cfg_random = value;
         rrws_pkg::REG_ONCE:   cfg_once = value;
         default: ;
      endcase
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic random_word(input int append_pct);
      logic cmd;
      logic [rrws_pkg::FIELD_W-1:0] lo, hi, cnt;
      logic [rrws_pkg::FRAC_W-1:0] frac;
      int j, r;
      cmd = ($urandom_range(0, 99) < append_pct) ? rrws_pkg::CMD_APPEND
                                                 : rrws_pkg::CMD_SELECT;
      lo = rrws_pkg::FIELD_W'($urandom);
      hi = rrws_pkg::FIELD_W'($urandom);
      cnt = rrws_pkg::FIELD_W'($urandom);
      frac = rrws_pkg::FRAC_W'($urandom);
      if (cmd == rrws_pkg::CMD_APPEND) begin
         r = $urandom_range(0, 9);
         if (r == 0) hi = '0;
         else if (r > 1) hi = lo + rrws_pkg::FIELD_W'($urandom_range(0, 255 - lo));
      end else begin
         if (fill > 0 && $urandom_range(0, 9) < 6) begin
            j = $urandom_range(0, fill - 1);
            if (win_lo[j] <= win_hi[j])
               cnt = rrws_pkg::FIELD_W'($urandom_range(win_hi[j], win_lo[j]));
         end
         r = $urandom_range(0, 9);
         if (r == 0) frac = '0;
         else if (r == 1) frac = '1;
      end
      send_word(cmd, lo, hi, cnt, frac, 1'b0, rrws_pkg::ST_SELECTED);
   endtask

   function automatic row_type word_row(logic cmd, logic [rrws_pkg::FIELD_W-1:0] lo,
                                        logic [rrws_pkg::FIELD_W-1:0] hi,
                                        logic [rrws_pkg::FIELD_W-1:0] cnt,
                                        logic [rrws_pkg::FRAC_W-1:0] frac, bit typed,
                                        rrws_pkg::status_type st);
      row_type r;
      r.kind = ROW_WORD;
      r.command = cmd;
      r.low = lo;
      r.high = hi;
      r.count = cnt;
      r.fraction = frac;
      r.reg_index = rrws_pkg::REG_ENABLE;
      r.reg_value = 1'b0;
      r.typed = typed;
      r.status = st;
      return r;
   endfunction

   function automatic row_type csr_row(rrws_pkg::csr_index_type idx, logic value);
      row_type r;
      r = word_row(rrws_pkg::CMD_SELECT, '0, '0, '0, '0, 1'b0, rrws_pkg::ST_SELECTED);
      r.kind = ROW_CSR;
      r.reg_index = idx;
      r.reg_value = value;
      return r;
   endfunction

   always @(posedge clock) begin
      pick_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_picks.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Unexpected word: status %0d index %0d", rsp_status,
                        rsp_selected_index);
         end else begin
            want = expected_picks.pop_front();
            if (rsp_status !== want.status || rsp_selected_index !== want.index) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Mismatch: expected status %0d index %0d, got status %0d index %0d",
                           want.status, want.index, rsp_status, rsp_selected_index);
            end
         end
      end
   end

   initial begin
      plan.push_back(word_row(rrws_pkg::CMD_SELECT, 8'd0, 8'd0, 8'd0, 16'h0000, 1'b1,
                              rrws_pkg::ST_IDLE));
      plan.push_back(word_row(rrws_pkg::CMD_APPEND, 8'd0, 8'd0, 8'd0, 16'h0000, 1'b1,
                              rrws_pkg::ST_APPENDED));
      plan.push_back(word_row(rrws_pkg::CMD_APPEND, 8'd0, 8'd255, 8'd0, 16'h0000, 1'b1,
                              rrws_pkg::ST_APPENDED));
      plan.push_back(word_row(rrws_pkg::CMD_APPEND, 8'd255, 8'd255, 8'd0, 16'h0000, 1'b1,
                              rrws_pkg::ST_APPENDED));
      plan.push_back(word_row(rrws_pkg::CMD_APPEND, 8'd10, 8'd20, 8'd0, 16'h0000, 1'b1,
                              rrws_pkg::ST_APPENDED));
      plan.push_back(word_row(rrws_pkg::CMD_APPEND, 8'd200, 8'd100, 8'd0, 16'h0000, 1'b1,
                              rrws_pkg::ST_APPENDED));
      plan.push_back(word_row(rrws_pkg::CMD_SELECT, 8'd0, 8'd0, 8'd0, 16'h0000, 1'b0,
                              rrws_pkg::ST_SELECTED));
      plan.push_back(word_row(rrws_pkg::CMD_SELECT, 8'd0, 8'd0, 8'd255, 16'h0000, 1'b0,
                              rrws_pkg::ST_SELECTED));
      plan.push_back(word_row(rrws_pkg::CMD_SELECT, 8'd0, 8'd0, 8'd15, 16'h0000, 1'b0,
                              rrws_pkg::ST_SELECTED));
      plan.push_back(word_row(rrws_pkg::CMD_SELECT, 8'd0, 8'd0, 8'd150, 16'h0000, 1'b0,
                              rrws_pkg::ST_SELECTED));
      plan.push_back(csr_row(rrws_pkg::REG_ONCE, 1'b1));
      plan.push_back(word_row(rrws_pkg::CMD_SELECT, 8'd0, 8'd0, 8'd15, 16'h0000, 1'b0,
                              rrws_pkg::ST_SELECTED));
      plan.push_back(word_row(rrws_pkg::CMD_SELECT, 8'd0, 8'd0, 8'd15, 16'h0000, 1'b0,
                              rrws_pkg::ST_SELECTED));
      plan.push_back(word_row(rrws_pkg::CMD_SELECT, 8'd0, 8'd0, 8'd15, 16'h0000, 1'b0,
                              rrws_pkg::ST_SELECTED));
      plan.push_back(word_row(rrws_pkg::CMD_SELECT, 8'd0, 8'd0, 8'd255, 16'h0000, 1'b0,
                              rrws_pkg::ST_SELECTED));
      plan.push_back(csr_row(rrws_pkg::REG_RANDOM, 1'b1));
      plan.push_back(word_row(rrws_pkg::CMD_SELECT, 8'd0, 8'd0, 8'd15, 16'h0000, 1'b0,
                              rrws_pkg::ST_SELECTED));
      plan.push_back(word_row(rrws_pkg::CMD_SELECT, 8'd0, 8'd0, 8'd0, 16'hffff, 1'b0,
                              rrws_pkg::ST_SELECTED));
      plan.push_back(csr_row(rrws_pkg::REG_ENABLE, 1'b0));
      plan.push_back(word_row(rrws_pkg::CMD_SELECT, 8'hff, 8'hff, 8'd12, 16'hffff, 1'b1,
                              rrws_pkg::ST_IDLE));
      plan.push_back(word_row(rrws_pkg::CMD_APPEND, 8'd1, 8'd1, 8'hff, 16'hffff, 1'b1,
                              rrws_pkg::ST_APPENDED));
      plan.push_back(csr_row(REG_UNUSED, 1'b1));
      plan.push_back(csr_row(rrws_pkg::REG_ENABLE, 1'b1));
      plan.push_back(csr_row(rrws_pkg::REG_RANDOM, 1'b0));
      plan.push_back(csr_row(rrws_pkg::REG_ONCE, 1'b0));
      plan.push_back(word_row(rrws_pkg::CMD_SELECT, 8'd0, 8'd0, 8'd1, 16'hffff, 1'b0,
                              rrws_pkg::ST_SELECTED));

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      gap_pct = 19;
      stall_pct = 87;
      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR)
            write_register(plan[i].reg_index, plan[i].reg_value);
         else
            send_word(plan[i].command, plan[i].low, plan[i].high, plan[i].count,
                      plan[i].fraction, plan[i].typed, plan[i].status);
      end

      for (int seg = 0; seg < SEGMENTS; seg++) begin
         gap_pct = (seg < 3) ? 19 : (seg < 6) ? 87 : 0;
         stall_pct = (seg < 3) ? 87 : (seg < 6) ? 19 : 0;
         write_register(rrws_pkg::REG_ENABLE, segment_mode[seg][0]);
         write_register(rrws_pkg::REG_RANDOM, segment_mode[seg][1]);
         write_register(rrws_pkg::REG_ONCE, segment_mode[seg][2]);
         if (seg == 4) write_register(REG_UNUSED, 1'b0);
         for (int w = 0; w < SEGMENT_WORDS; w++) begin
            if (fill >= TABLE_DEPTH) seg_append_pct = 5;
            else seg_append_pct = (seg < 5) ? 20 : 50;
            random_word(seg_append_pct);
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;
      drain = 0;
      while (expected_picks.size() != 0 && drain < 5000) begin
         @(posedge clock);
         drain++;
      end
      repeat (300) @(posedge clock);
      if (expected_picks.size() != 0) begin
         mismatches += expected_picks.size();
         $display("%0d expected words never arrived", expected_picks.size());
      end

      $display("Sent %0d words across %0d register settings; the table grew to %0d entries.",
               words_sent, SEGMENTS + 1, fill);
      $display("Selections: %0d hits, %0d with no eligible entry, %0d full-table refusals.",
               hits, misses, refusals);
      if (mismatches == 0)
         $display("round_robin_window_selector_top_tb passed");
      else
         $display("round_robin_window_selector_top_tb failed");
      $finish;
   end

   initial begin
      #8000000;
      $display("round_robin_window_selector_top_tb failed");
      $finish;
   end

endmodule
